// File: design/signed_restoring_divider_core_macros.svh
// Assertion macros used by the divider core module.
`ifndef SIGNED_RESTORING_DIVIDER_CORE_MACROS_SVH
`define SIGNED_RESTORING_DIVIDER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srd assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define SRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srd assertion failed: next-cycle implication");

`endif

// File: design/srd_pkg.sv
`default_nettype none

package srd_pkg;

   localparam int unsigned DIV_WIDTH = 16;

   localparam logic [DIV_WIDTH-1:0] DIV_MIN_NEG = {1'b1, {(DIV_WIDTH-1){1'b0}}};
   localparam logic [DIV_WIDTH-1:0] DIV_MAX_POS = {1'b0, {(DIV_WIDTH-1){1'b1}}};
   localparam logic [DIV_WIDTH-1:0] DIV_ALL_ONES = {DIV_WIDTH{1'b1}};
   localparam logic [DIV_WIDTH-1:0] DIV_ZERO_VAL = {DIV_WIDTH{1'b0}};

   // Latency from an accepted transaction to its result strobe.
   localparam int unsigned DIV_LATENCY = DIV_WIDTH + 3;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIV_ZERO = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      ALG_RESTORING     = 1'b0,
      ALG_NON_RESTORING = 1'b1
   } algorithm_type;

   typedef struct packed {
      logic signed [DIV_WIDTH-1:0] dividend;
      logic signed [DIV_WIDTH-1:0] divisor;
   } req_type;

   typedef struct packed {
      logic signed [DIV_WIDTH-1:0] quotient;
      logic signed [DIV_WIDTH-1:0] remainder;
      status_type                  status;
   } rsp_type;

   // One division in flight between two pipeline stages.
   typedef struct packed {
      logic [DIV_WIDTH:0]   rem;
      logic [DIV_WIDTH-1:0] quo;
      logic [DIV_WIDTH-1:0] dmag;
      logic [DIV_WIDTH-1:0] dividend;
      logic                 nneg;
      logic                 dneg;
      status_type           status;
      algorithm_type        alg;
   } work_type;

endpackage

`default_nettype wire

// File: design/srd_prep.sv
`default_nettype none

module srd_prep
   import srd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire req_type       in_req,
   input  wire algorithm_type alg,
   output logic               out_valid,
   output work_type           out_item
);

   logic     valid_ff;
   work_type item_ff;
   work_type item_in;

   logic [DIV_WIDTH-1:0] dividend_bits;
   logic [DIV_WIDTH-1:0] divisor_bits;

   always_comb begin
      dividend_bits = in_req.dividend;
      divisor_bits  = in_req.divisor;

      item_in.nneg     = dividend_bits[DIV_WIDTH-1];
      item_in.dneg     = divisor_bits[DIV_WIDTH-1];
      item_in.rem      = '0;
      item_in.quo      = item_in.nneg ? (DIV_ZERO_VAL - dividend_bits) : dividend_bits;
      item_in.dmag     = item_in.dneg ? (DIV_ZERO_VAL - divisor_bits) : divisor_bits;
      item_in.dividend = dividend_bits;
      item_in.alg      = alg;

      priority if (divisor_bits == DIV_ZERO_VAL) begin
         item_in.status = STATUS_DIV_ZERO;
      end else if (dividend_bits == DIV_MIN_NEG && divisor_bits == DIV_ALL_ONES) begin
         item_in.status = STATUS_OVERFLOW;
      end else begin
         item_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// File: design/srd_step.sv
`default_nettype none

module srd_step
   import srd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   input  wire work_type in_item,
   output logic          out_valid,
   output work_type      out_item
);

   logic     valid_ff;
   work_type item_ff;
   work_type item_in;

   logic [DIV_WIDTH:0] shifted;
   logic [DIV_WIDTH:0] dext;
   logic [DIV_WIDTH:0] diff;
   logic [DIV_WIDTH:0] sum;
   logic [DIV_WIDTH:0] trial;

   always_comb begin
      shifted = {in_item.rem[DIV_WIDTH-1:0], in_item.quo[DIV_WIDTH-1]};
      dext    = {1'b0, in_item.dmag};
      diff    = shifted - dext;
      sum     = shifted + dext;
      trial   = diff;
      item_in = in_item;
      item_in.quo = {in_item.quo[DIV_WIDTH-2:0], 1'b0};

      unique case (in_item.alg)
         ALG_RESTORING: begin
            if (diff[DIV_WIDTH]) begin
               item_in.rem = shifted;
            end else begin
               item_in.rem    = diff;
               item_in.quo[0] = 1'b1;
            end
         end
         ALG_NON_RESTORING: begin
            trial          = shifted[DIV_WIDTH] ? sum : diff;
            item_in.rem    = trial;
            item_in.quo[0] = ~trial[DIV_WIDTH];
         end
         default: begin
            item_in.rem = shifted;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// File: design/srd_fix.sv
`default_nettype none

module srd_fix
   import srd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   input  wire work_type in_item,
   output logic          out_valid,
   output rsp_type       out_rsp
);

   // First stage: remainder correction for a negative partial remainder.
   logic     corr_valid_ff;
   work_type corr_item_ff;
   work_type corr_item_in;

   // Second stage: sign fix-up and the special cases.
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic [DIV_WIDTH-1:0] quo_mag;
   logic [DIV_WIDTH-1:0] rem_mag;

   always_comb begin
      corr_item_in = in_item;
      if (in_item.rem[DIV_WIDTH]) begin
         corr_item_in.rem = in_item.rem + {1'b0, in_item.dmag};
      end
   end

   always_comb begin
      quo_mag = corr_item_ff.quo;
      rem_mag = corr_item_ff.rem[DIV_WIDTH-1:0];
      rsp_in.status = corr_item_ff.status;

      unique case (corr_item_ff.status)
         STATUS_DIV_ZERO: begin
            rsp_in.quotient  = DIV_ZERO_VAL;
            rsp_in.remainder = corr_item_ff.dividend;
         end
         STATUS_OVERFLOW: begin
            rsp_in.quotient  = DIV_MAX_POS;
            rsp_in.remainder = DIV_ZERO_VAL;
         end
         default: begin
            rsp_in.quotient  = (corr_item_ff.nneg ^ corr_item_ff.dneg) ?
                               (DIV_ZERO_VAL - quo_mag) : quo_mag;
            rsp_in.remainder = corr_item_ff.nneg ? (DIV_ZERO_VAL - rem_mag) : rem_mag;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corr_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         corr_valid_ff <= in_valid;
         rsp_valid_ff  <= corr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      corr_item_ff <= corr_item_in;
      rsp_ff       <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire

// File: design/signed_restoring_divider_core.sv
// Channel      Handshake               Payload
// request      start / busy            req_data (dividend, divisor)
// response     rsp_strobe              rsp_data (quotient, remainder, status)
// register     csr_valid / csr_ready   csr_data (algorithm select)
//
// A transaction is accepted in any cycle in which start is high and busy is low.
// Its result is strobed after passing through one input stage, one pipeline stage per
// quotient bit, a correction stage and an output stage. A new transaction may enter
// in every cycle in which busy is low.
// Busy is high during reset and for the cycle after; reset drops all transactions.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

`include "signed_restoring_divider_core_macros.svh"

module signed_restoring_divider_core
   import srd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_data
);

   logic          busy_ff;
   algorithm_type alg_ff;
   algorithm_type alg_in;
   logic          req_accept;

   logic     step_valid [0:DIV_WIDTH];
   work_type step_item  [0:DIV_WIDTH];

   assign req_accept = start & ~busy_ff;
   assign busy       = busy_ff;
   assign csr_ready  = ~busy_ff;
   assign alg_in     = (csr_valid && csr_ready) ? algorithm_type'(csr_data) : alg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         alg_ff  <= ALG_RESTORING;
      end else begin
         busy_ff <= 1'b0;
         alg_ff  <= alg_in;
      end
   end

   srd_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_req    (req_data),
      .alg       (alg_ff),
      .out_valid (step_valid[0]),
      .out_item  (step_item[0])
   );

   for (genvar g = 0; g < DIV_WIDTH; g++) begin : g_step
      srd_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (step_valid[g]),
         .in_item   (step_item[g]),
         .out_valid (step_valid[g+1]),
         .out_item  (step_item[g+1])
      );
   end

   srd_fix u_fix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step_valid[DIV_WIDTH]),
      .in_item   (step_item[DIV_WIDTH]),
      .out_valid (rsp_strobe),
      .out_rsp   (rsp_data)
   );

   `SRD_ASSERT_IMPLY(a_latency, clock, reset, req_accept, ##(DIV_LATENCY) rsp_strobe)
   `SRD_ASSERT_IMPLY(a_div_zero_quotient, clock, reset, rsp_strobe && rsp_data.status == STATUS_DIV_ZERO, rsp_data.quotient == DIV_ZERO_VAL)
   `SRD_ASSERT_IMPLY(a_overflow_result, clock, reset, rsp_strobe && rsp_data.status == STATUS_OVERFLOW, rsp_data.remainder == DIV_ZERO_VAL && rsp_data.quotient == DIV_MAX_POS)

endmodule

`default_nettype wire
